// File: hw/rtl/page_frame_allocator_refcount_macros.svh
// ----------------------------------------------------------------------------
// Page frame allocator assertion macros
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define PFA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PFA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define PFA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)

`endif

`endif

// File: hw/rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Sizes, request and response types, codes and controller interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

  localparam int NUM_FRAMES  = 4096;
  localparam int COUNT_BITS  = 16;
  localparam int FRAME_BITS  = 12;
  localparam int FLAG_BITS   = 16;
  localparam int VALUE_BITS  = 16;
  localparam int KIND_BITS   = 3;
  localparam int STATUS_BITS = 3;

  localparam int FRAME_LIMIT = 1 << FRAME_BITS;
  // Frames that really exist: bounded by the pool size and the frame field
  localparam int MEM_FRAMES  = (NUM_FRAMES < FRAME_LIMIT) ? NUM_FRAMES : FRAME_LIMIT;
  localparam int MEM_AW      = $clog2(MEM_FRAMES);
  localparam int STK_AW      = $clog2(NUM_FRAMES);
  localparam int STK_CW      = $clog2(NUM_FRAMES + 1);
  localparam int FM_W        = COUNT_BITS + FLAG_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers
  localparam int CFG_W     = FRAME_BITS + 1;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_POOL_FIRST = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_POOL_END   = 1'b1;
  localparam logic [CFG_W-1:0]     POOL_END_RESET = CFG_W'(FRAME_LIMIT);

  // Request kinds
  localparam logic [KIND_BITS-1:0] KIND_ALLOC    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_FREE     = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_REF_INC  = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_REF_DEC  = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_REF_READ = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_FLAG_SET = 3'd5;
  localparam logic [KIND_BITS-1:0] KIND_FLAG_CLR = 3'd6;
  localparam logic [KIND_BITS-1:0] KIND_FLAG_TST = 3'd7;

  // Status codes
  localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_NO_FRAME  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_SATURATED = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_STACK_FULL = 3'd4;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [FRAME_BITS-1:0] frame;
    logic [FLAG_BITS-1:0]  flag_mask;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [FRAME_BITS-1:0]  result_frame;
    logic [VALUE_BITS-1:0]  value;
    logic                   was_freed;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // write one zero entry of the frame memory
    logic accept;  // latch request, issue memory reads
    logic commit;  // write back state, load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// Page frame allocator controller
// Sequences the clearing pass and the read / write-back of each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfa_ctrl
  import pfa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept = in_valid && !in_stall;
        if (cmd.accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register can take the response
        cmd.commit = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_stall <= 1'b1;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pfa_datapath.sv
// ----------------------------------------------------------------------------
// Page frame allocator datapath
// Frame state memory, free stack, bump pointer, config and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfa_datapath
  import pfa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output stat_t                     stat,
  input  wire req_t                 in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output rsp_t                      out_data,
  input  wire logic                 wr_en,
  input  wire logic [REG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]     wr_data
);

  localparam logic [FRAME_BITS:0] MEM_FRAMES_W = (FRAME_BITS + 1)'(MEM_FRAMES);
  localparam logic [STK_CW-1:0]   STK_FULL     = STK_CW'(NUM_FRAMES);
  localparam logic [MEM_AW-1:0]   CLR_LAST     = MEM_AW'(MEM_FRAMES - 1);

  // frame memory entry: {refcount, flags}
  logic [FM_W-1:0]       fmem [MEM_FRAMES];
  logic [FRAME_BITS-1:0] smem [NUM_FRAMES];

  logic [CFG_W-1:0]      pool_end;
  logic [CFG_W-1:0]      bump_next;
  logic [STK_CW-1:0]     stack_count;
  logic [MEM_AW-1:0]     clr_addr;

  req_t                  req;
  logic [FM_W-1:0]       fm_rd;
  logic [FRAME_BITS-1:0] stk_rd;

  logic [STK_CW-1:0]     stack_top;
  logic [COUNT_BITS-1:0] rc;
  logic [FLAG_BITS-1:0]  fl;
  logic [CFG_W-1:0]      bump_limit;
  logic                  stack_empty;
  logic                  stack_full;
  logic                  in_range;

  rsp_t                  rsp;
  logic                  fm_we;
  logic [MEM_AW-1:0]     fm_addr;
  logic [FM_W-1:0]       fm_wdata;
  logic                  push;
  logic                  pop;
  logic                  bump_inc;

  assign stack_top   = stack_count - STK_CW'(1);
  assign stack_empty = (stack_count == '0);
  assign stack_full  = (stack_count == STK_FULL);
  assign rc          = fm_rd[FM_W-1:FLAG_BITS];
  assign fl          = fm_rd[FLAG_BITS-1:0];
  assign in_range    = ({1'b0, req.frame} < MEM_FRAMES_W);
  assign bump_limit  = (pool_end < CFG_W'(MEM_FRAMES)) ? pool_end : CFG_W'(MEM_FRAMES);

  assign stat.clear_last = (clr_addr == CLR_LAST);
  assign stat.out_free   = !out_valid || !out_stall;

  always_comb begin
    rsp      = '{status: ST_OK, result_frame: req.frame, value: '0, was_freed: 1'b0};
    fm_we    = 1'b0;
    fm_addr  = req.frame[MEM_AW-1:0];
    fm_wdata = '0;
    push     = 1'b0;
    pop      = 1'b0;
    bump_inc = 1'b0;
    if (req.kind == KIND_ALLOC) begin
      if (!stack_empty) begin
        pop = 1'b1;
        if ({1'b0, stk_rd} < MEM_FRAMES_W) begin
          fm_we            = 1'b1;
          fm_addr          = stk_rd[MEM_AW-1:0];
          fm_wdata         = {COUNT_BITS'(1), {FLAG_BITS{1'b0}}};
          rsp.result_frame = stk_rd;
          rsp.value        = VALUE_BITS'(1);
        end else begin
          rsp.status       = ST_NO_FRAME;
          rsp.result_frame = '0;
        end
      end else if (bump_next < bump_limit) begin
        bump_inc         = 1'b1;
        fm_we            = 1'b1;
        fm_addr          = bump_next[MEM_AW-1:0];
        fm_wdata         = {COUNT_BITS'(1), {FLAG_BITS{1'b0}}};
        rsp.result_frame = bump_next[FRAME_BITS-1:0];
        rsp.value        = VALUE_BITS'(1);
      end else begin
        rsp.status       = ST_NO_FRAME;
        rsp.result_frame = '0;
      end
    end else if (in_range) begin
      case (req.kind)
        KIND_FREE: begin
          if (!stack_full) begin
            push          = 1'b1;
            fm_we         = 1'b1;
            rsp.was_freed = 1'b1;
          end else begin
            rsp.status = ST_STACK_FULL;
            rsp.value  = VALUE_BITS'(rc);
          end
        end
        KIND_REF_INC: begin
          if (rc == COUNT_MAX) begin
            rsp.status = ST_SATURATED;
            rsp.value  = VALUE_BITS'(rc);
          end else begin
            fm_we     = 1'b1;
            fm_wdata  = {rc + COUNT_BITS'(1), fl};
            rsp.value = VALUE_BITS'(rc + COUNT_BITS'(1));
          end
        end
        KIND_REF_DEC: begin
          if (rc == '0) begin
            rsp.status = ST_UNDERFLOW;
          end else if (rc == COUNT_BITS'(1)) begin
            // last reference dropped: return frame to the stack unless it is full
            if (!stack_full) begin
              push          = 1'b1;
              fm_we         = 1'b1;
              rsp.was_freed = 1'b1;
            end else begin
              rsp.status = ST_STACK_FULL;
              rsp.value  = VALUE_BITS'(rc);
            end
          end else begin
            fm_we     = 1'b1;
            fm_wdata  = {rc - COUNT_BITS'(1), fl};
            rsp.value = VALUE_BITS'(rc - COUNT_BITS'(1));
          end
        end
        KIND_REF_READ: rsp.value = VALUE_BITS'(rc);
        KIND_FLAG_SET: begin
          fm_we     = 1'b1;
          fm_wdata  = {rc, fl | req.flag_mask};
          rsp.value = VALUE_BITS'(rc);
        end
        KIND_FLAG_CLR: begin
          fm_we     = 1'b1;
          fm_wdata  = {rc, fl & ~req.flag_mask};
          rsp.value = VALUE_BITS'(rc);
        end
        KIND_FLAG_TST: rsp.value = VALUE_BITS'(|(fl & req.flag_mask));
        default: rsp.value = '0;
      endcase
    end
  end

  // Frame state memory: single write port shared with the clearing pass
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      fmem[clr_addr] <= '0;
    end else if (cmd.commit && fm_we) begin
      fmem[fm_addr] <= fm_wdata;
    end
    if (cmd.accept) begin
      fm_rd <= fmem[in_data.frame[MEM_AW-1:0]];
    end
  end

  // Free stack memory
  always_ff @(posedge clk) begin
    if (cmd.commit && push) begin
      smem[stack_count[STK_AW-1:0]] <= req.frame;
    end
    if (cmd.accept) begin
      stk_rd <= smem[stack_top[STK_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) req <= in_data;
    if (cmd.commit) out_data <= rsp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_end    <= POOL_END_RESET;
      bump_next   <= '0;
      stack_count <= '0;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + MEM_AW'(1);
      if (wr_en && wr_index == REG_POOL_FIRST) begin
        // reload the bump pointer from the new pool start
        bump_next <= {1'b0, wr_data[FRAME_BITS-1:0]};
      end else if (cmd.commit && bump_inc) begin
        bump_next <= bump_next + CFG_W'(1);
      end
      if (wr_en && wr_index == REG_POOL_END) pool_end <= wr_data;
      if (cmd.commit && push) stack_count <= stack_count + STK_CW'(1);
      else if (cmd.commit && pop) stack_count <= stack_top;
      if (cmd.commit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/page_frame_allocator_refcount.sv
// ----------------------------------------------------------------------------
// Page frame allocator with reference counts
// Top level: controller and datapath, with request and response channels.
// ----------------------------------------------------------------------------
// Each request first reads the frame state memory and the top of the free
// stack, then writes the updated entry back and loads the response register.
// A new request is taken once the previous response has been loaded; the
// response register lets the consumer stall without losing it, and a stall
// holds the write-back only while that register is full. After reset the
// frame state memory is cleared one entry a cycle, covering all MEM_FRAMES
// (4096) entries; requests are stalled meanwhile, while configuration writes
// are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

`include "page_frame_allocator_refcount_macros.svh"

module page_frame_allocator_refcount
  import pfa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire req_t                 in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output rsp_t                      out_data,
  input  wire logic                 wr_en,
  input  wire logic [REG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]     wr_data
);

  cmd_t  cmd;
  stat_t stat;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  pfa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  `PFA_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall,
                  "request accepted while previous one in flight")
  `PFA_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.commit, !(out_valid && out_stall),
                  "response register overwritten while stalled")
  `PFA_ASSERT_NXT(a_commit_gives_rsp, clk, rst, cmd.commit, out_valid,
                  "committed request left no response")

endmodule

`default_nettype wire
